FILE: src/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the radial stick dead zone
// Field widths, fixed-point formats, cell payload types and output saturation.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int IN_W       = 9;
    localparam int OUT_W      = 11;
    localparam int DZ_W       = 7;
    localparam int FULL_SCALE = 128;
    localparam int FRAC_BITS  = 8;

    localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(30);

    localparam int IN_DATA_W  = ((2 * IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    localparam int SQ_W   = 2 * IN_W;
    localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
    localparam int MAG_W  = RAD_W / 2;
    localparam int REM_W  = MAG_W + 2;
    localparam int FS_W   = $clog2(FULL_SCALE + 1);
    localparam int NUM_W  = IN_W + FS_W + MAG_W;
    localparam int DEN_W  = MAG_W + FS_W;
    localparam int Q_W    = OUT_W + 1;
    localparam int REMD_W = DEN_W + Q_W;

    localparam logic [Q_W-1:0] POS_LIMIT = Q_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(1 << (OUT_W - 1));

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [RAD_W-1:0]       rad;
        logic [MAG_W-1:0]       root;
        logic [REM_W-1:0]       rem;
    } sq_t;

    typedef struct packed {
        logic [REMD_W-1:0] rem_x;
        logic [REMD_W-1:0] rem_y;
        logic [DEN_W-1:0]  den;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
        logic              neg_x;
        logic              neg_y;
        logic              zero;
        logic              dead;
    } dv_t;

    function automatic logic signed [OUT_W-1:0] sat_axis(
        input logic [Q_W-1:0] q,
        input logic           neg,
        input logic           zero
    );
        logic signed [OUT_W-1:0] res;
        if (zero)
        begin
            res = '0;
        end
        else if (neg)
        begin
            res = (q > NEG_LIMIT) ? OUT_W'(NEG_LIMIT) : OUT_W'(-q);
        end
        else
        begin
            res = (q > POS_LIMIT) ? OUT_W'(POS_LIMIT) : OUT_W'(q);
        end
        return res;
    endfunction

endpackage

FILE: src/rsd_square_cell.sv
// ----------------------------------------------------------------------------
// rsd_square_cell: entry cell
// Registers a sample with the sum of squares of both axes as square-root radicand.
// ----------------------------------------------------------------------------
module rsd_square_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [rsd_pkg::IN_W-1:0] x,
    input  logic signed [rsd_pkg::IN_W-1:0] y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rsd_pkg::sq_t                    out_pl
);

    logic                       valid_reg;
    rsd_pkg::sq_t               pl_reg;
    rsd_pkg::sq_t               pl_next;
    logic [rsd_pkg::IN_W-1:0]   ax;
    logic [rsd_pkg::IN_W-1:0]   ay;
    logic [rsd_pkg::SQ_W-1:0]   axw;
    logic [rsd_pkg::SQ_W-1:0]   ayw;
    logic [rsd_pkg::SQ_W-1:0]   sq;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pl    = pl_reg;

    always_comb
    begin
        ax  = x[rsd_pkg::IN_W-1] ? rsd_pkg::IN_W'(-x) : rsd_pkg::IN_W'(x);
        ay  = y[rsd_pkg::IN_W-1] ? rsd_pkg::IN_W'(-y) : rsd_pkg::IN_W'(y);
        axw = rsd_pkg::SQ_W'(ax);
        ayw = rsd_pkg::SQ_W'(ay);
        sq  = axw * axw + ayw * ayw;
        pl_next.x    = x;
        pl_next.y    = y;
        pl_next.rad  = {sq, {(2 * rsd_pkg::FRAC_BITS){1'b0}}};
        pl_next.root = '0;
        pl_next.rem  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pl_reg <= pl_next;
        end
    end

endmodule

FILE: src/rsd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsd_sqrt_cell: one digit of the square root
// Settles one root bit from the next two radicand bits and hands on the rest.
// ----------------------------------------------------------------------------
module rsd_sqrt_cell
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rsd_pkg::sq_t in_pl,
    output logic         out_valid,
    input  logic         out_ready,
    output rsd_pkg::sq_t out_pl
);

    logic                      valid_reg;
    rsd_pkg::sq_t              pl_reg;
    rsd_pkg::sq_t              pl_next;
    logic [rsd_pkg::REM_W-1:0] rem_sh;
    logic [rsd_pkg::REM_W-1:0] trial;
    logic                      ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pl    = pl_reg;

    always_comb
    begin
        rem_sh = {in_pl.rem[rsd_pkg::REM_W-3:0], in_pl.rad[rsd_pkg::RAD_W-1:rsd_pkg::RAD_W-2]};
        trial  = {in_pl.root, 2'b01};
        ge     = rem_sh >= trial;
        pl_next.x    = in_pl.x;
        pl_next.y    = in_pl.y;
        pl_next.rad  = in_pl.rad << 2;
        pl_next.root = {in_pl.root[rsd_pkg::MAG_W-2:0], ge};
        pl_next.rem  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pl_reg <= pl_next;
        end
    end

endmodule

FILE: src/rsd_scale_cell.sv
// ----------------------------------------------------------------------------
// rsd_scale_cell: dead-zone test and operand set-up
// Compares the magnitude with the radius and forms dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
module rsd_scale_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rsd_pkg::DZ_W-1:0]  dead_zone,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rsd_pkg::sq_t              in_pl,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rsd_pkg::dv_t              out_pl
);

    logic                       valid_reg;
    rsd_pkg::dv_t               pl_reg;
    rsd_pkg::dv_t               pl_next;
    logic [rsd_pkg::MAG_W-1:0]  mag;
    logic [rsd_pkg::MAG_W-1:0]  dq;
    logic [rsd_pkg::MAG_W-1:0]  diff;
    logic [rsd_pkg::FS_W:0]     dz_w;
    logic [rsd_pkg::FS_W:0]     fs_w;
    logic                       span_neg;
    logic [rsd_pkg::FS_W-1:0]   span_abs;
    logic [rsd_pkg::IN_W-1:0]   ax;
    logic [rsd_pkg::IN_W-1:0]   ay;
    logic                       dead;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pl    = pl_reg;

    always_comb
    begin
        mag      = in_pl.root;
        dq       = rsd_pkg::MAG_W'({dead_zone, {rsd_pkg::FRAC_BITS{1'b0}}});
        dead     = mag < dq;
        diff     = mag - dq;
        dz_w     = (rsd_pkg::FS_W + 1)'(dead_zone);
        fs_w     = (rsd_pkg::FS_W + 1)'(rsd_pkg::FULL_SCALE);
        span_neg = dz_w > fs_w;
        span_abs = span_neg ? rsd_pkg::FS_W'(dz_w - fs_w) : rsd_pkg::FS_W'(fs_w - dz_w);
        ax = in_pl.x[rsd_pkg::IN_W-1] ? rsd_pkg::IN_W'(-in_pl.x) : rsd_pkg::IN_W'(in_pl.x);
        ay = in_pl.y[rsd_pkg::IN_W-1] ? rsd_pkg::IN_W'(-in_pl.y) : rsd_pkg::IN_W'(in_pl.y);
        pl_next.rem_x = rsd_pkg::REMD_W'(rsd_pkg::NUM_W'(ax) * rsd_pkg::NUM_W'(rsd_pkg::FULL_SCALE)
                                         * rsd_pkg::NUM_W'(diff));
        pl_next.rem_y = rsd_pkg::REMD_W'(rsd_pkg::NUM_W'(ay) * rsd_pkg::NUM_W'(rsd_pkg::FULL_SCALE)
                                         * rsd_pkg::NUM_W'(diff));
        pl_next.den   = rsd_pkg::DEN_W'(mag) * rsd_pkg::DEN_W'(span_abs);
        pl_next.q_x   = '0;
        pl_next.q_y   = '0;
        pl_next.neg_x = in_pl.x[rsd_pkg::IN_W-1] ^ span_neg;
        pl_next.neg_y = in_pl.y[rsd_pkg::IN_W-1] ^ span_neg;
        pl_next.zero  = dead || (mag == '0) || (span_abs == '0);
        pl_next.dead  = dead;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pl_reg <= pl_next;
        end
    end

endmodule

FILE: src/rsd_div_cell.sv
// ----------------------------------------------------------------------------
// rsd_div_cell: one quotient bit of both axis divisions
// Restoring division step at a fixed divisor shift, for both axes side by side.
// ----------------------------------------------------------------------------
module rsd_div_cell
#(
    parameter int SHIFT = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rsd_pkg::dv_t in_pl,
    output logic         out_valid,
    input  logic         out_ready,
    output rsd_pkg::dv_t out_pl
);

    logic                       valid_reg;
    rsd_pkg::dv_t               pl_reg;
    rsd_pkg::dv_t               pl_next;
    logic [rsd_pkg::REMD_W-1:0] den_sh;
    logic                       ge_x;
    logic                       ge_y;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pl    = pl_reg;

    always_comb
    begin
        den_sh  = rsd_pkg::REMD_W'(in_pl.den) << SHIFT;
        ge_x    = in_pl.rem_x >= den_sh;
        ge_y    = in_pl.rem_y >= den_sh;
        pl_next = in_pl;
        pl_next.rem_x = ge_x ? in_pl.rem_x - den_sh : in_pl.rem_x;
        pl_next.rem_y = ge_y ? in_pl.rem_y - den_sh : in_pl.rem_y;
        pl_next.q_x   = {in_pl.q_x[rsd_pkg::Q_W-2:0], ge_x};
        pl_next.q_y   = {in_pl.q_y[rsd_pkg::Q_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pl_reg <= pl_next;
        end
    end

endmodule

FILE: src/rsd_out_cell.sv
// ----------------------------------------------------------------------------
// rsd_out_cell: output register
// Applies sign, saturation and the zero cases and holds the result for transfer.
// ----------------------------------------------------------------------------
module rsd_out_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rsd_pkg::dv_t                     in_pl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [rsd_pkg::OUT_W-1:0] scaled_x,
    output logic signed [rsd_pkg::OUT_W-1:0] scaled_y,
    output logic                             in_dead_zone
);

    logic                             valid_reg;
    logic signed [rsd_pkg::OUT_W-1:0] sx_reg;
    logic signed [rsd_pkg::OUT_W-1:0] sy_reg;
    logic                             dead_reg;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign scaled_x     = sx_reg;
    assign scaled_y     = sy_reg;
    assign in_dead_zone = dead_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sx_reg   <= rsd_pkg::sat_axis(in_pl.q_x, in_pl.neg_x, in_pl.zero);
            sy_reg   <= rsd_pkg::sat_axis(in_pl.q_y, in_pl.neg_y, in_pl.zero);
            dead_reg <= in_pl.dead;
        end
    end

endmodule

FILE: src/radial_scaled_stick_deadzone_top.sv
// ----------------------------------------------------------------------------
// radial_scaled_stick_deadzone_top: scaled radial dead zone for a thumbstick
// A sample passes a row of cells, each with its own valid and local ready: one
// squaring cell, one cell per square-root bit (17), a dead-zone and operand cell,
// one cell per quotient bit (12) and the output register, 32 cells in all. A
// transfer is taken every cycle while the input is not stalled; bubbles close
// up, so input stalls only when every cell is full. The dead-zone register
// resets to 30 and is written with cfg_we.
// ----------------------------------------------------------------------------
module radial_scaled_stick_deadzone_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsd_pkg::DZ_W-1:0]         cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rsd_pkg::IN_DATA_W-1:0]    s_tdata,   // stick_x, stick_y, zero fill
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rsd_pkg::OUT_DATA_W-1:0]   m_tdata,   // scaled_x, scaled_y, zero fill
    output logic                             m_tuser    // in_dead_zone
);

    localparam int NSQ = rsd_pkg::MAG_W;
    localparam int NDV = rsd_pkg::Q_W;

    logic [rsd_pkg::DZ_W-1:0]         dead_zone_reg;
    rsd_pkg::sq_t                     sq_pl [0:NSQ];
    logic                             sq_v  [0:NSQ];
    logic                             sq_r  [0:NSQ];
    rsd_pkg::dv_t                     dv_pl [0:NDV];
    logic                             dv_v  [0:NDV];
    logic                             dv_r  [0:NDV];
    logic signed [rsd_pkg::OUT_W-1:0] scaled_x;
    logic signed [rsd_pkg::OUT_W-1:0] scaled_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= rsd_pkg::DZ_RESET;
        end
        else if (cfg_we)
        begin
            dead_zone_reg <= cfg_wdata;
        end
    end

    rsd_square_cell u_square
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x         (s_tdata[rsd_pkg::IN_W-1:0]),
        .y         (s_tdata[2*rsd_pkg::IN_W-1:rsd_pkg::IN_W]),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_pl    (sq_pl[0])
    );

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        rsd_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_pl     (sq_pl[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_pl    (sq_pl[k+1])
        );
    end

    rsd_scale_cell u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dead_zone (dead_zone_reg),
        .in_valid  (sq_v[NSQ]),
        .in_ready  (sq_r[NSQ]),
        .in_pl     (sq_pl[NSQ]),
        .out_valid (dv_v[0]),
        .out_ready (dv_r[0]),
        .out_pl    (dv_pl[0])
    );

    for (genvar k = 0; k < NDV; k++)
    begin : g_div
        rsd_div_cell #(.SHIFT(NDV - 1 - k)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[k]),
            .in_ready  (dv_r[k]),
            .in_pl     (dv_pl[k]),
            .out_valid (dv_v[k+1]),
            .out_ready (dv_r[k+1]),
            .out_pl    (dv_pl[k+1])
        );
    end

    rsd_out_cell u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dv_v[NDV]),
        .in_ready     (dv_r[NDV]),
        .in_pl        (dv_pl[NDV]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .scaled_x     (scaled_x),
        .scaled_y     (scaled_y),
        .in_dead_zone (m_tuser)
    );

    assign m_tdata = rsd_pkg::OUT_DATA_W'({scaled_y, scaled_x});

endmodule

FILE: src/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker: port-level checks of the dead-zone block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rsd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic [rsd_pkg::DZ_W-1:0]       cfg_wdata,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rsd_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rsd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Output changed while a transfer was pending.");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2*rsd_pkg::OUT_W-1:0] == '0)
        else $error("Dead-zone result carries nonzero axis values.");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled while the output was free.");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("Result shown right after reset.");

endmodule

bind radial_scaled_stick_deadzone_top rsd_checker u_rsd_checker (.*);
